// File: hdl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define CHK_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, checked only while reset is released.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/rchsu_pkg.sv
// Package for the hybrid switch unpacker: constants, result types, switch scaling.
// No dependencies.
package rchsu_pkg;

	localparam int unsigned NUM_CH    = 4;
	localparam int unsigned CH_BITS   = 10;
	localparam int unsigned OUT_BITS  = 11;
	localparam int unsigned SLOT_BITS = 3;

	localparam logic [OUT_BITS-1:0]  CH_OFFSET = 11'd988;
	localparam logic [OUT_BITS-1:0]  SW_LOW    = 11'd1000;
	localparam logic [OUT_BITS-1:0]  SW_HIGH   = 11'd2000;
	localparam logic [SLOT_BITS-1:0] SLOT_NONE = 3'd7;

	// ceil(1000 * 2^16 / 127); exact floor for any 7-bit value.
	localparam logic [26:0] SW_RECIP = 27'd516032;

	localparam logic FUNC_NONCE  = 1'b0;
	localparam logic FUNC_PACKET = 1'b1;

	typedef struct packed {
		logic [SLOT_BITS-1:0] slot;
		logic [OUT_BITS-1:0]  value;
		logic                 valid;
	} rchsu_switch_t;

	typedef struct packed {
		logic [NUM_CH-1:0][OUT_BITS-1:0] analog;
		logic [OUT_BITS-1:0]             arm;
		rchsu_switch_t                   sw;
	} rchsu_result_t;

	// v * 1000 / 127 + 1000 through a reciprocal multiply.
	function automatic logic [OUT_BITS-1:0] scale_switch(input logic [6:0] v);
		logic [26:0] prod;
		prod = 27'(v) * SW_RECIP;
		return prod[26:16] + SW_LOW;
	endfunction

endpackage

// File: hdl/rchsu_lane.sv
// One analog channel lane: offsets a 10-bit packed field into the output range.
// Depends on rchsu_pkg.
module rchsu_lane
	import rchsu_pkg::*;
(
	input  logic [CH_BITS-1:0]  field,
	output logic [OUT_BITS-1:0] chan
);

	assign chan = {1'b0, field} + CH_OFFSET;

endmodule

// File: hdl/rchsu_switch.sv
// Round-robin switch lane: holds the slot index from nonce words and scales the switch byte.
// Depends on rchsu_pkg.
module rchsu_switch
	import rchsu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          nonce_we,
	input  logic [7:0]    nonce,
	input  logic [7:0]    switch_raw,
	output rchsu_switch_t sw
);

	logic [SLOT_BITS-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (nonce_we) begin
			// Low three bits plus bit 3, wrapping at eight.
			slot_q <= nonce[2:0] + {2'b00, nonce[3]};
		end
	end

	always_comb begin
		sw.slot = slot_q;
		if (slot_q != SLOT_NONE) begin
			sw.value = scale_switch(switch_raw[6:0]);
			sw.valid = 1'b1;
		end else begin
			sw.value = '0;
			sw.valid = 1'b0;
		end
	end

endmodule

// File: hdl/rchsu_merge.sv
// Merge stage: gathers the lane results into the output register, with a skid
// register that takes one more word while a word waits. Depends on rchsu_pkg.
module rchsu_merge
	import rchsu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rchsu_result_t res,
	input  logic          out_stall,
	output logic          in_stall,
	output logic          out_valid,
	output rchsu_result_t out_res
);

	logic          out_valid_q;
	logic          skid_full_q;
	rchsu_result_t out_q;
	rchsu_result_t skid_q;
	logic          out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_full_q || load;
			skid_full_q <= 1'b0;
		end else if (load) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_full_q ? skid_q : res;
		end else if (load) begin
			skid_q <= res;
		end
	end

	assign in_stall  = skid_full_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// File: hdl/rc_packet_hybrid_switch_unpack.sv
// Channel  Handshake             Payload
// input    in_valid / in_stall   func, nonce, packed_channels, low_latency_bit, switch_raw
// output   out_valid / out_stall analog_ch0..3, arm_switch, switch_slot, switch_level, switch_valid
//
// One word is accepted per cycle while in_stall is low; a packet word is registered in the
// output register, or in the skid register while the output is stalled. Nonce words update
// the slot register at acceptance and give no output word. in_stall is high while the skid
// register holds a word: from the cycle after a packet meets a stalled output until the output register frees up.
// arst_n clears the slot index to zero and empties both output registers.
// Depends on rchsu_pkg, rchsu_lane, rchsu_switch, rchsu_merge.
module rc_packet_hybrid_switch_unpack
	import rchsu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [7:0]           nonce,
	input  logic [39:0]          packed_channels,
	input  logic                 low_latency_bit,
	input  logic [7:0]           switch_raw,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_BITS-1:0]  analog_ch0,
	output logic [OUT_BITS-1:0]  analog_ch1,
	output logic [OUT_BITS-1:0]  analog_ch2,
	output logic [OUT_BITS-1:0]  analog_ch3,
	output logic [OUT_BITS-1:0]  arm_switch,
	output logic [SLOT_BITS-1:0] switch_slot,
	output logic [OUT_BITS-1:0]  switch_level,
	output logic                 switch_valid
);

	logic          accept;
	logic          nonce_we;
	logic          pkt_load;
	rchsu_result_t res;
	rchsu_result_t out_res;

	assign accept   = in_valid && !in_stall;
	assign nonce_we = accept && (func == FUNC_NONCE);
	assign pkt_load = accept && (func == FUNC_PACKET);

	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		rchsu_lane u_lane (
			.field (packed_channels[k*CH_BITS +: CH_BITS]),
			.chan  (res.analog[k])
		);
	end

	rchsu_switch u_switch (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonce_we   (nonce_we),
		.nonce      (nonce),
		.switch_raw (switch_raw),
		.sw         (res.sw)
	);

	assign res.arm = low_latency_bit ? SW_HIGH : SW_LOW;

	rchsu_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (pkt_load),
		.res       (res),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign analog_ch0   = out_res.analog[0];
	assign analog_ch1   = out_res.analog[1];
	assign analog_ch2   = out_res.analog[2];
	assign analog_ch3   = out_res.analog[3];
	assign arm_switch   = out_res.arm;
	assign switch_slot  = out_res.sw.slot;
	assign switch_level = out_res.sw.value;
	assign switch_valid = out_res.sw.valid;

endmodule

// File: hdl/rchsu_checker.sv
// Port-level checker for the hybrid switch unpacker, bound to the top level.
// Depends on rchsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rchsu_checker
	import rchsu_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 func,
	input logic [7:0]           nonce,
	input logic [39:0]          packed_channels,
	input logic                 low_latency_bit,
	input logic [7:0]           switch_raw,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [OUT_BITS-1:0]  analog_ch0,
	input logic [OUT_BITS-1:0]  analog_ch1,
	input logic [OUT_BITS-1:0]  analog_ch2,
	input logic [OUT_BITS-1:0]  analog_ch3,
	input logic [OUT_BITS-1:0]  arm_switch,
	input logic [SLOT_BITS-1:0] switch_slot,
	input logic [OUT_BITS-1:0]  switch_level,
	input logic                 switch_valid
);

	// A valid switch word is scaled into the switch range and never uses slot seven.
	`CHK_IMPLIES(a_sw_range, clk, arst_n, out_valid && switch_valid,
		switch_slot != SLOT_NONE && switch_level >= SW_LOW && switch_level <= SW_HIGH)

	// Slot seven, and only slot seven, leaves the switch value empty.
	`CHK_IMPLIES(a_sw_none, clk, arst_n, out_valid && !switch_valid,
		switch_slot == SLOT_NONE && switch_level == '0)

	`CHK_IMPLIES(a_arm_code, clk, arst_n, out_valid,
		arm_switch == SW_LOW || arm_switch == SW_HIGH)

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(analog_ch0) && $stable(switch_level))

endmodule

bind rc_packet_hybrid_switch_unpack rchsu_checker u_rchsu_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rc_packet_hybrid_switch_unpack: directed and random words,
// checked against an in-bench predictor under several idle and stall mixes.
// Depends on rchsu_pkg and the rc_packet_hybrid_switch_unpack RTL.
module tb;
	import rchsu_pkg::*;

	localparam int unsigned HOLD_CYCLES = 80;

	typedef struct packed {
		logic        func;
		logic [7:0]  nonce;
		logic [39:0] packed_channels;
		logic        low_latency_bit;
		logic [7:0]  switch_raw;
	} channel_word_t;

	typedef struct packed {
		logic [NUM_CH-1:0][OUT_BITS-1:0] analog;
		logic [OUT_BITS-1:0]             arm;
		logic [SLOT_BITS-1:0]            slot;
		logic [OUT_BITS-1:0]             value;
		logic                            valid;
	} unpacked_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = 1'b0;
	logic [7:0]           nonce = '0;
	logic [39:0]          packed_channels = '0;
	logic                 low_latency_bit = 1'b0;
	logic [7:0]           switch_raw = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [OUT_BITS-1:0]  analog_ch0;
	logic [OUT_BITS-1:0]  analog_ch1;
	logic [OUT_BITS-1:0]  analog_ch2;
	logic [OUT_BITS-1:0]  analog_ch3;
	logic [OUT_BITS-1:0]  arm_switch;
	logic [SLOT_BITS-1:0] switch_slot;
	logic [OUT_BITS-1:0]  switch_level;
	logic                 switch_valid;

	channel_word_t        pending_words[$];
	unpacked_word_t       expected_results[$];
	logic [SLOT_BITS-1:0] slot_model = '0;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_reqs = 0;
	int unsigned hold_done = 0;
	int unsigned hold_left = 0;

	int unsigned fail_count = 0;
	int unsigned nonce_count = 0;
	int unsigned packet_count = 0;
	int unsigned slot_seven_count = 0;
	int unsigned in_stall_cycles = 0;

	rc_packet_hybrid_switch_unpack u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.nonce           (nonce),
		.packed_channels (packed_channels),
		.low_latency_bit (low_latency_bit),
		.switch_raw      (switch_raw),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.analog_ch0      (analog_ch0),
		.analog_ch1      (analog_ch1),
		.analog_ch2      (analog_ch2),
		.analog_ch3      (analog_ch3),
		.arm_switch      (arm_switch),
		.switch_slot     (switch_slot),
		.switch_level    (switch_level),
		.switch_valid    (switch_valid)
	);

	always #5 clk = ~clk;

	// The slot is the low three nonce bits, plus one when nonce bit 3 is set, wrapping at eight.
	function automatic logic [SLOT_BITS-1:0] slot_after_nonce(input logic [7:0] n);
		return SLOT_BITS'(n[2:0] + n[3]);
	endfunction

	function automatic unpacked_word_t predict_unpack(input channel_word_t w,
			input logic [SLOT_BITS-1:0] slot);
		unpacked_word_t r;
		int unsigned    level;
		for (int k = 0; k < NUM_CH; k++)
			r.analog[k] = {1'b0, w.packed_channels[k*CH_BITS +: CH_BITS]} + CH_OFFSET;
		r.arm  = w.low_latency_bit ? SW_HIGH : SW_LOW;
		r.slot = slot;
		if (slot < SLOT_NONE) begin
			level   = int'(w.switch_raw[6:0]) * 1000 / 127 + int'(SW_LOW);
			r.value = OUT_BITS'(level);
			r.valid = 1'b1;
		end else begin
			r.value = '0;
			r.valid = 1'b0;
		end
		return r;
	endfunction

	function automatic channel_word_t make_word(input logic f, input logic [7:0] n,
			input logic [39:0] pc, input logic llb, input logic [7:0] sb);
		channel_word_t w;
		w.func            = f;
		w.nonce           = n;
		w.packed_channels = pc;
		w.low_latency_bit = llb;
		w.switch_raw      = sb;
		return w;
	endfunction

	// Channel fields lean toward their extremes now and then.
	function automatic channel_word_t random_word(input int unsigned nonce_share);
		channel_word_t w;
		int unsigned   pick;
		w.func            = ($urandom_range(99) < nonce_share) ? FUNC_NONCE : FUNC_PACKET;
		w.nonce           = 8'($urandom_range(255));
		w.low_latency_bit = 1'($urandom_range(1));
		w.switch_raw      = 8'($urandom_range(255));
		for (int k = 0; k < NUM_CH; k++) begin
			pick = $urandom_range(9);
			w.packed_channels[k*CH_BITS +: CH_BITS] = (pick == 0) ? 10'h000 :
				(pick == 1) ? 10'h3FF : 10'($urandom_range(1023));
		end
		return w;
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [OUT_BITS-1:0] want,
			input logic [OUT_BITS-1:0] got);
		if (got !== want)
			log_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
	endtask

	// Sender: a new word is offered only once the current one is taken or none is offered.
	always @(posedge clk) begin : sender
		channel_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
				w = pending_words.pop_front();
				in_valid        <= 1'b1;
				func            <= w.func;
				nonce           <= w.nonce;
				packed_channels <= w.packed_channels;
				low_latency_bit <= w.low_latency_bit;
				switch_raw      <= w.switch_raw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off counted here when one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_reqs) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= hold_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: predict on input acceptance, then check any output word taken at this edge.
	always @(posedge clk) begin : monitor
		channel_word_t  w;
		unpacked_word_t want;
		if (arst_n) begin
			if (in_valid && in_stall)
				in_stall_cycles++;
			if (in_valid && in_stall === 1'b0) begin
				w = {func, nonce, packed_channels, low_latency_bit, switch_raw};
				if (w.func == FUNC_NONCE) begin
					slot_model = slot_after_nonce(w.nonce);
					nonce_count++;
				end else begin
					expected_results.push_back(predict_unpack(w, slot_model));
					packet_count++;
				end
			end
			if (out_valid === 1'b1 && !out_stall) begin
				if (expected_results.size() == 0) begin
					log_failure("output word arrived with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (want.slot == SLOT_NONE)
						slot_seven_count++;
					compare_field("analog_ch0", want.analog[0], analog_ch0);
					compare_field("analog_ch1", want.analog[1], analog_ch1);
					compare_field("analog_ch2", want.analog[2], analog_ch2);
					compare_field("analog_ch3", want.analog[3], analog_ch3);
					compare_field("arm_switch", want.arm, arm_switch);
					compare_field("switch_slot", OUT_BITS'(want.slot), OUT_BITS'(switch_slot));
					compare_field("switch_level", want.value, switch_level);
					compare_field("switch_valid", OUT_BITS'(want.valid),
						OUT_BITS'(switch_valid));
				end
			end
		end
	end

	task automatic run_phase(input int unsigned count, input int unsigned idle,
			input int unsigned stall, input int unsigned nonce_share, input bit with_hold);
		@(posedge clk);
		idle_pct  <= idle;
		stall_pct <= stall;
		repeat (count)
			pending_words.push_back(random_word(nonce_share));
		if (with_hold)
			hold_reqs <= hold_reqs + 1;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Packets before any nonce use the reset slot; bit 7 of the switch byte is dropped.
		pending_words.push_back(make_word(FUNC_PACKET, 8'hFF, 40'hFF_FFFF_FFFF, 1'b1, 8'hFF));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h00, 40'h00_0000_0000, 1'b0, 8'h00));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h07, 40'hAA_AAAA_AAAA, 1'b1, 8'h80));
		// Slot seven suppresses the switch value.
		pending_words.push_back(make_word(FUNC_NONCE, 8'h07, 40'hFF_FFFF_FFFF, 1'b1, 8'hFF));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h00, 40'h55_5555_5555, 1'b0, 8'h7F));
		pending_words.push_back(make_word(FUNC_PACKET, 8'hFF, 40'hFF_C000_03FF, 1'b1, 8'h01));
		// Bit 3 pushes seven past the top and wraps to zero.
		pending_words.push_back(make_word(FUNC_NONCE, 8'h0F, 40'h00_0000_0000, 1'b0, 8'h00));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h07, 40'h00_3FF0_0000, 1'b0, 8'h7F));
		pending_words.push_back(make_word(FUNC_NONCE, 8'h08, 40'h12_3456_789A, 1'b1, 8'h55));
		pending_words.push_back(make_word(FUNC_PACKET, 8'hAA, 40'h12_3456_789A, 1'b1, 8'h01));
		pending_words.push_back(make_word(FUNC_NONCE, 8'hF7, 40'h00_0000_0000, 1'b0, 8'h00));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h00, 40'hFF_FFFF_FFFF, 1'b0, 8'hFE));
		pending_words.push_back(make_word(FUNC_NONCE, 8'hFF, 40'hFF_FFFF_FFFF, 1'b1, 8'hFF));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h55, 40'h80_2008_0200, 1'b1, 8'h40));
		pending_words.push_back(make_word(FUNC_NONCE, 8'h0E, 40'h00_0000_0000, 1'b0, 8'h00));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h00, 40'h7F_DFF7_FDFF, 1'b0, 8'h3F));
		pending_words.push_back(make_word(FUNC_NONCE, 8'h06, 40'h00_0000_0000, 1'b0, 8'h00));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h00, 40'h00_0000_0001, 1'b1, 8'hC0));
		pending_words.push_back(make_word(FUNC_NONCE, 8'h00, 40'h00_0000_0000, 1'b0, 8'h00));
		pending_words.push_back(make_word(FUNC_PACKET, 8'h00, 40'h80_0000_0000, 1'b0, 8'h7F));
		while (pending_words.size() != 0)
			@(posedge clk);

		run_phase(150, 0, 0, 30, 1'b0);
		run_phase(150, 55, 0, 30, 1'b0);
		run_phase(150, 0, 55, 30, 1'b0);
		run_phase(150, 24, 24, 30, 1'b0);
		// Output held off while the sender keeps pushing, so the input side must stall.
		run_phase(60, 0, 0, 10, 1'b1);

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		stall_pct <= 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("tb: %0d nonce words and %0d packets sent, %0d results on slot seven",
			nonce_count, packet_count, slot_seven_count);
		$display("tb: input held back for %0d cycles across five idle and stall mixes",
			in_stall_cycles);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#500000;
		$display("tb: failure");
		$finish;
	end

endmodule
